/* rtl/core/ffba_pkg.sv */
// ffba_pkg: shared constants, codes and types of the first-fit block allocator.
// No dependencies; imported by the interfaces, the RAM users and the top level.

package ffba_pkg;

	// Table geometry
	localparam int MAX_BLOCKS = 64;
	localparam int IDX_W      = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
	localparam int CNT_W      = $clog2(MAX_BLOCKS + 1);

	// Field widths
	localparam int ADDR_W   = 32;
	localparam int HDR_W    = 8;
	localparam int STATUS_W = 3;
	localparam int CFG_IDX_W = 2;

	// Register reset values
	localparam logic [ADDR_W-1:0] HEAP_BASE_RST  = 32'h0000_0000;
	localparam logic [ADDR_W-1:0] HEAP_LIMIT_RST = 32'hFFFF_FFFF;
	localparam logic [HDR_W-1:0]  HEADER_RST     = 8'd12;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_HEAP_BASE  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_HEAP_LIMIT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_HEADER     = 2'd2;

	// Request kinds
	localparam logic MODE_ALLOC   = 1'b0;
	localparam logic MODE_RELEASE = 1'b1;

	// Result status codes
	typedef enum logic [STATUS_W-1:0] {
		ST_OK      = 3'd0,
		ST_NULL    = 3'd1,
		ST_LIMIT   = 3'd2,
		ST_FULL    = 3'd3,
		ST_UNKNOWN = 3'd4
	} status_t;

	// One table entry as stored in the block RAM
	typedef struct packed {
		logic [ADDR_W-1:0] blk_start;
		logic [ADDR_W-1:0] blk_size;
		logic              blk_free;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

endpackage

/* rtl/core/ffba_req_if.sv */
// ffba_req_if: request channel of the allocator (valid/ready plus request fields).
// Depends on ffba_pkg for field widths.

interface ffba_req_if;
	import ffba_pkg::*;

	logic              valid;
	logic              ready;
	logic              mode;
	logic [ADDR_W-1:0] request_size;
	logic [ADDR_W-1:0] payload_address;

	modport source (output valid, output mode, output request_size,
		output payload_address, input ready);
	modport sink (input valid, input mode, input request_size,
		input payload_address, output ready);

endinterface

/* rtl/core/ffba_rsp_if.sv */
// ffba_rsp_if: response channel of the allocator (valid/ready plus result fields).
// Depends on ffba_pkg for field widths.

interface ffba_rsp_if;
	import ffba_pkg::*;

	logic                valid;
	logic                ready;
	logic [ADDR_W-1:0]   result_address;
	logic [STATUS_W-1:0] status;
	logic                reused;

	modport source (output valid, output result_address, output status,
		output reused, input ready);
	modport sink (input valid, input result_address, input status,
		input reused, output ready);

endinterface

/* rtl/core/ffba_ram.sv */
// ffba_ram: generic simple dual-port RAM, one write and one registered read port.
// No dependencies.

module ffba_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* rtl/core/first_fit_block_allocator_top.sv */
// first_fit_block_allocator_top: first-fit heap block table with break pointer.
// Depends on ffba_pkg, ffba_req_if, ffba_rsp_if and ffba_ram.
//
//  channel | dir | handshake            | payload
//  --------+-----+----------------------+-------------------------------------------
//  req     | in  | valid/ready          | mode, request_size, payload_address
//  rsp     | out | valid/ready          | result_address, status, reused
//  cfg     | in  | cfg_we (no wait)     | cfg_index, cfg_wdata
//
// Flow: an item that needs a table walk reads the live entries in order until a hit,
// an append after a full walk passes through APPEND too; null requests and requests on
// an empty table skip the walk. The walk reads one entry per cycle from the table RAM.
// Reset: table count and FSM clear at once; the table RAM needs no clearing pass.
// Stalls: a new item is taken while the previous result sits in the output
// register; an item's result waits in DONE until the output register is free.

module first_fit_block_allocator_top (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [ffba_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [ffba_pkg::ADDR_W-1:0]       cfg_wdata,
	ffba_req_if.sink                          req,
	ffba_rsp_if.source                        rsp
);
	import ffba_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE   = 4'b0001,
		S_SCAN   = 4'b0010,
		S_APPEND = 4'b0100,
		S_DONE   = 4'b1000
	} fsm_t;

	fsm_t state_q;

	// Configuration and global state
	logic [ADDR_W-1:0] limit_q;
	logic [HDR_W-1:0]  hdr_q;
	logic [CNT_W-1:0]  count_q;
	logic [ADDR_W-1:0] break_q;

	// Latched request
	logic              mode_q;
	logic [ADDR_W-1:0] size_q;
	logic [ADDR_W-1:0] addr_q;

	// Walk control
	logic [IDX_W-1:0]  scan_idx_q;
	logic              issued_all_q;
	logic              rd_valid_s1;
	logic [IDX_W-1:0]  idx_s1;

	// Pending result and output register
	logic [ADDR_W-1:0] res_addr_q;
	status_t           res_status_q;
	logic              res_reused_q;
	logic              out_valid_q;
	logic [ADDR_W-1:0] out_addr_q;
	status_t           out_status_q;
	logic              out_reused_q;

	// RAM ports
	logic              mem_we;
	logic [IDX_W-1:0]  mem_waddr;
	entry_t            mem_wdata;
	logic              issue;
	logic [ENTRY_W-1:0] mem_rdata;
	entry_t            rd_entry;

	// Datapath terms
	logic [CNT_W-1:0]  last_cnt;
	logic [IDX_W-1:0]  last_idx;
	logic              check;
	logic [ADDR_W-1:0] payload_s1;
	logic              alloc_fit;
	logic              free_match;
	logic              hit;
	logic              at_last;
	logic              pop_ok;
	logic [ADDR_W+1:0] next_brk;
	logic              full;
	logic              over;
	logic              append_ok;
	logic              out_free;

	ffba_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (MAX_BLOCKS)
	) u_table (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (issue),
		.raddr (scan_idx_q),
		.rdata (mem_rdata)
	);

	assign rd_entry = entry_t'(mem_rdata);

	// Walk issue and per-entry checks
	always_comb begin
		last_cnt   = count_q - CNT_W'(1);
		last_idx   = last_cnt[IDX_W-1:0];
		issue      = (state_q == S_SCAN) && !issued_all_q;
		check      = (state_q == S_SCAN) && rd_valid_s1;
		payload_s1 = rd_entry.blk_start + {{(ADDR_W-HDR_W){1'b0}}, hdr_q};
		alloc_fit  = rd_entry.blk_free && (rd_entry.blk_size >= size_q);
		free_match = (payload_s1 == addr_q);
		hit        = check && ((mode_q == MODE_ALLOC) ? alloc_fit : free_match);
		at_last    = (idx_s1 == last_idx);
		pop_ok     = at_last &&
			(({1'b0, addr_q} + {1'b0, rd_entry.blk_size}) == {1'b0, break_q});
	end

	// Append checks: table full first, then heap limit
	always_comb begin
		next_brk  = {2'b00, break_q} + {{(ADDR_W+2-HDR_W){1'b0}}, hdr_q} +
			{2'b00, size_q};
		full      = (count_q == CNT_W'(MAX_BLOCKS));
		over      = (next_brk > {2'b00, limit_q});
		append_ok = (state_q == S_APPEND) && !full && !over;
	end

	// Table write-back: mark used/free on a hit (none when a release pops the last entry), or store the new block
	always_comb begin
		mem_we    = append_ok || (hit && !((mode_q == MODE_RELEASE) && pop_ok));
		mem_waddr = (state_q == S_APPEND) ? count_q[IDX_W-1:0] : idx_s1;
		if (state_q == S_APPEND) begin
			mem_wdata.blk_start = break_q;
			mem_wdata.blk_size  = size_q;
			mem_wdata.blk_free  = 1'b0;
		end else begin
			mem_wdata.blk_start = rd_entry.blk_start;
			mem_wdata.blk_size  = rd_entry.blk_size;
			mem_wdata.blk_free  = (mode_q == MODE_RELEASE);
		end
	end

	assign out_free = !out_valid_q || rsp.ready;

	// Channel outputs
	assign req.ready          = (state_q == S_IDLE);
	assign rsp.valid          = out_valid_q;
	assign rsp.result_address = out_addr_q;
	assign rsp.status         = out_status_q;
	assign rsp.reused         = out_reused_q;

	// Read pipeline stage (payload, no reset needed beyond valid)
	always_ff @(posedge clk) begin
		idx_s1 <= scan_idx_q;
	end

	// Control, configuration and result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			limit_q      <= HEAP_LIMIT_RST;
			hdr_q        <= HEADER_RST;
			count_q      <= '0;
			break_q      <= HEAP_BASE_RST;
			issued_all_q <= 1'b0;
			rd_valid_s1  <= 1'b0;
			scan_idx_q   <= '0;
			out_valid_q  <= 1'b0;
			mode_q       <= MODE_ALLOC;
			size_q       <= '0;
			addr_q       <= '0;
			res_addr_q   <= '0;
			res_status_q <= ST_OK;
			res_reused_q <= 1'b0;
			out_addr_q   <= '0;
			out_status_q <= ST_OK;
			out_reused_q <= 1'b0;
		end else begin
			rd_valid_s1 <= issue;

			// Register writes; the host must write only while idle, which the block does not enforce
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_HEAP_BASE: begin
						if (count_q == '0) begin
							break_q <= cfg_wdata;
						end
					end
					CFG_HEAP_LIMIT: limit_q <= cfg_wdata;
					CFG_HEADER:     hdr_q   <= cfg_wdata[HDR_W-1:0];
					default: ;
				endcase
			end

			// Output register drains unless DONE reloads it this cycle
			if (out_valid_q && rsp.ready && (state_q != S_DONE)) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						mode_q       <= req.mode;
						size_q       <= req.request_size;
						addr_q       <= req.payload_address;
						scan_idx_q   <= '0;
						issued_all_q <= 1'b0;
						res_addr_q   <= '0;
						res_reused_q <= 1'b0;
						if (req.mode == MODE_ALLOC) begin
							priority if (req.request_size == '0) begin
								res_status_q <= ST_NULL;
								state_q      <= S_DONE;
							end else if (count_q == '0) begin
								res_status_q <= ST_OK;
								state_q      <= S_APPEND;
							end else begin
								res_status_q <= ST_OK;
								state_q      <= S_SCAN;
							end
						end else begin
							priority if (req.payload_address == '0) begin
								res_status_q <= ST_NULL;
								state_q      <= S_DONE;
							end else if (count_q == '0) begin
								res_status_q <= ST_UNKNOWN;
								state_q      <= S_DONE;
							end else begin
								res_status_q <= ST_OK;
								state_q      <= S_SCAN;
							end
						end
					end
				end

				S_SCAN: begin
					// Issue one read per cycle up to the last entry
					if (issue) begin
						if (scan_idx_q == last_idx) begin
							issued_all_q <= 1'b1;
						end else begin
							scan_idx_q <= scan_idx_q + IDX_W'(1);
						end
					end
					// Evaluate the entry read last cycle
					if (hit) begin
						state_q <= S_DONE;
						if (mode_q == MODE_ALLOC) begin
							res_addr_q   <= payload_s1;
							res_reused_q <= 1'b1;
						end else if (pop_ok) begin
							count_q <= last_cnt;
							break_q <= rd_entry.blk_start;
						end
					end else if (check && at_last) begin
						if (mode_q == MODE_ALLOC) begin
							state_q <= S_APPEND;
						end else begin
							res_status_q <= ST_UNKNOWN;
							state_q      <= S_DONE;
						end
					end
				end

				S_APPEND: begin
					priority if (full) begin
						res_status_q <= ST_FULL;
					end else if (over) begin
						res_status_q <= ST_LIMIT;
					end else begin
						count_q    <= count_q + CNT_W'(1);
						break_q    <= next_brk[ADDR_W-1:0];
						res_addr_q <= break_q + {{(ADDR_W-HDR_W){1'b0}}, hdr_q};
					end
					state_q <= S_DONE;
				end

				S_DONE: begin
					if (out_free) begin
						out_valid_q  <= 1'b1;
						out_addr_q   <= res_addr_q;
						out_status_q <= res_status_q;
						out_reused_q <= res_reused_q;
						state_q      <= S_IDLE;
					end
				end

				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	// Block count never exceeds the table depth
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_BLOCKS))
		else $error("block count beyond table depth");

	// Table writes happen only during a walk hit or an append
	a_we_state: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (state_q == S_SCAN || state_q == S_APPEND))
		else $error("table write outside walk or append");

	// A successful append grows the table by exactly one entry
	a_append_count: assert property (@(posedge clk) disable iff (!arst_n)
		append_ok |=> count_q == $past(count_q) + CNT_W'(1))
		else $error("append did not advance block count");

	// A finished item reaches the output register once it is free
	a_done_load: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && out_free) |=> (out_valid_q && state_q == S_IDLE))
		else $error("result not loaded into output register");

	// Walk reads never run past the last live entry
	a_walk_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN && rd_valid_s1) |-> idx_s1 <= last_idx)
		else $error("walk read beyond last entry");
`endif

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// tb_top: self-checking testbench for first_fit_block_allocator_top (table, break, registers).
// Depends on ffba_pkg, ffba_req_if, ffba_rsp_if and the allocator RTL; needs no other file.

module tb_top;
	import ffba_pkg::*;

	localparam int CLK_HALF_NS    = 6;
	localparam int RESET_CYCLES   = 10;
	localparam int NUM_PHASES     = 12;
	localparam int NUM_DIRECTED   = 22;
	localparam int HOLD_CYCLES    = 400;
	localparam int SETTLE_CYCLES  = 80;
	localparam int WATCHDOG_LIMIT = 5000;

	// One result item as the block returns it
	typedef struct packed {
		logic [ADDR_W-1:0] addr;
		status_t           status;
		logic              reused;
	} grant_t;

	// One row of the directed table; typed rows carry their own result
	typedef struct packed {
		logic              mode;
		logic [ADDR_W-1:0] size;
		logic [ADDR_W-1:0] addr;
		logic              typed;
		grant_t            exp;
	} step_row_t;

	localparam grant_t NO_GRANT = '{ADDR_W'(0), ST_OK, 1'b0};

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [ADDR_W-1:0]    cfg_wdata;

	ffba_req_if req_ch ();
	ffba_rsp_if rsp_ch ();

	first_fit_block_allocator_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.req       (req_ch),
		.rsp       (rsp_ch)
	);

	always #(CLK_HALF_NS) clk = ~clk;

	// Shadow copy of the heap table and registers
	logic [ADDR_W-1:0] tbl_start [MAX_BLOCKS];
	logic [ADDR_W-1:0] tbl_size  [MAX_BLOCKS];
	logic              tbl_free  [MAX_BLOCKS];
	int                tbl_count;
	logic [ADDR_W-1:0] heap_brk;
	logic [ADDR_W-1:0] base_reg;
	logic [ADDR_W-1:0] limit_reg;
	logic [HDR_W-1:0]  hdr_reg;

	grant_t pending_grants [$];
	int     fail_count   = 0;
	int     items_sent   = 0;
	int     results_seen = 0;
	int     reused_seen  = 0;
	int     status_seen [8];
	int     req_idle_pct = 25;
	int     rsp_idle_pct = 25;
	int     hold_asks    = 0;
	int     settings_run = 0;
	int     quiet_cycles = 0;

	// Stimulus in the directed part, from the reset settings
	step_row_t directed_rows [NUM_DIRECTED] = '{
		'{MODE_ALLOC,   32'd0,          32'hFFFF_FFFF, 1'b1, '{32'd0,  ST_NULL,    1'b0}},
		'{MODE_RELEASE, 32'hFFFF_FFFF,  32'd0,         1'b1, '{32'd0,  ST_NULL,    1'b0}},
		'{MODE_RELEASE, 32'd0,          32'hFFFF_FFFF, 1'b1, '{32'd0,  ST_UNKNOWN, 1'b0}},
		'{MODE_ALLOC,   32'd1,          32'd0,         1'b1, '{32'd12, ST_OK,      1'b0}},
		'{MODE_ALLOC,   32'hFFFF_FFFF,  32'hFFFF_FFFF, 1'b1, '{32'd0,  ST_LIMIT,   1'b0}},
		'{MODE_ALLOC,   32'd100,        32'd0,         1'b1, '{32'd25, ST_OK,      1'b0}},
		'{MODE_ALLOC,   32'h7FFF_FFFF,  32'hFFFF_FFFF, 1'b0, NO_GRANT},
		'{MODE_RELEASE, 32'd0,          32'd25,        1'b0, NO_GRANT},
		'{MODE_ALLOC,   32'd50,         32'd0,         1'b0, NO_GRANT},
		'{MODE_RELEASE, 32'hFFFF_FFFF,  32'd137,       1'b0, NO_GRANT},
		'{MODE_RELEASE, 32'd0,          32'd137,       1'b1, '{32'd0,  ST_UNKNOWN, 1'b0}},
		'{MODE_RELEASE, 32'hFFFF_FFFF,  32'd26,        1'b0, NO_GRANT},
		'{MODE_RELEASE, 32'd0,          32'd12,        1'b0, NO_GRANT},
		'{MODE_RELEASE, 32'hFFFF_FFFF,  32'd12,        1'b0, NO_GRANT},
		'{MODE_ALLOC,   32'd2,          32'd0,         1'b0, NO_GRANT},
		'{MODE_RELEASE, 32'd0,          32'd25,        1'b0, NO_GRANT},
		'{MODE_RELEASE, 32'hFFFF_FFFF,  32'd137,       1'b0, NO_GRANT},
		'{MODE_RELEASE, 32'd0,          32'd25,        1'b0, NO_GRANT},
		'{MODE_RELEASE, 32'hFFFF_FFFF,  32'd12,        1'b0, NO_GRANT},
		'{MODE_ALLOC,   32'hFFFF_FFF3,  32'hFFFF_FFFF, 1'b1, '{32'd12, ST_OK,      1'b0}},
		'{MODE_ALLOC,   32'd1,          32'd0,         1'b1, '{32'd0,  ST_LIMIT,   1'b0}},
		'{MODE_RELEASE, 32'd0,          32'd12,        1'b0, NO_GRANT}
	};

	// Expected result of one request; updates the shadow table as the block does
	function automatic grant_t predict_heap_op(input logic mode, input logic [ADDR_W-1:0] size,
		input logic [ADDR_W-1:0] addr);
		grant_t            g;
		logic [ADDR_W+1:0] new_brk;
		int                hit;
		g = NO_GRANT;
		hit = -1;
		if (mode == MODE_ALLOC) begin
			if (size == '0) begin
				g.status = ST_NULL;
			end else begin
				// first fit over the live entries
				for (int i = 0; i < tbl_count; i++) begin
					if (tbl_free[i] && tbl_size[i] >= size) begin
						hit = i;
						break;
					end
				end
				new_brk = (ADDR_W+2)'(heap_brk) + (ADDR_W+2)'(hdr_reg) + (ADDR_W+2)'(size);
				if (hit >= 0) begin
					tbl_free[hit] = 1'b0;
					g.addr = tbl_start[hit] + ADDR_W'(hdr_reg);
					g.reused = 1'b1;
				end else if (tbl_count >= MAX_BLOCKS) begin
					g.status = ST_FULL;
				end else if (new_brk > (ADDR_W+2)'(limit_reg)) begin
					g.status = ST_LIMIT;
				end else begin
					// append at the break
					tbl_start[tbl_count] = heap_brk;
					tbl_size[tbl_count] = size;
					tbl_free[tbl_count] = 1'b0;
					g.addr = heap_brk + ADDR_W'(hdr_reg);
					tbl_count++;
					heap_brk = new_brk[ADDR_W-1:0];
				end
			end
		end else if (addr == '0) begin
			g.status = ST_NULL;
		end else begin
			// lookup uses the header size in force now
			for (int i = 0; i < tbl_count; i++) begin
				if (ADDR_W'(tbl_start[i] + ADDR_W'(hdr_reg)) == addr) begin
					hit = i;
					break;
				end
			end
			if (hit < 0) begin
				g.status = ST_UNKNOWN;
			end else if (hit == tbl_count - 1 && (ADDR_W+2)'(addr) + (ADDR_W+2)'(tbl_size[hit])
				== (ADDR_W+2)'(heap_brk)) begin
				heap_brk = tbl_start[hit];
				tbl_count--;
			end else begin
				tbl_free[hit] = 1'b1;
			end
		end
		return g;
	endfunction

	// Write all three registers back to back while the block is idle
	task automatic apply_config(input logic [ADDR_W-1:0] base, input logic [ADDR_W-1:0] limit,
		input logic [HDR_W-1:0] hdr);
		cfg_we <= 1'b1;
		cfg_index <= CFG_HEAP_BASE;
		cfg_wdata <= base;
		@(posedge clk);
		cfg_index <= CFG_HEAP_LIMIT;
		cfg_wdata <= limit;
		@(posedge clk);
		cfg_index <= CFG_HEADER;
		cfg_wdata <= ADDR_W'(hdr);
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		// a new base only moves the break while the table is empty
		base_reg = base;
		if (tbl_count == 0)
			heap_brk = base;
		limit_reg = limit;
		hdr_reg = hdr;
		settings_run++;
	endtask

	// Offer one item, wait for the handshake, then queue what it should return
	task automatic offer_request(input logic mode, input logic [ADDR_W-1:0] size,
		input logic [ADDR_W-1:0] addr, input logic typed, input grant_t typed_exp);
		grant_t g;
		while ($urandom_range(0, 99) < req_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.mode <= mode;
		req_ch.request_size <= size;
		req_ch.payload_address <= addr;
		do @(posedge clk); while (req_ch.ready !== 1'b1);
		g = predict_heap_op(mode, size, addr);
		pending_grants.push_back(typed ? typed_exp : g);
		items_sent++;
	endtask

	// Mostly well-formed traffic: releases aim at live payloads, allocs often fit a hole
	task automatic random_request(input int alloc_pct, input int small_max, input bit big_ok);
		logic [ADDR_W-1:0] size;
		logic [ADDR_W-1:0] addr;
		int                pick;
		int                j;
		size = $urandom;
		addr = $urandom;
		pick = $urandom_range(0, 99);
		if ($urandom_range(0, 99) < alloc_pct) begin
			if (pick < 5) begin
				size = '0;
			end else if (pick < 8) begin
				if (!big_ok)
					size = $urandom_range(1, small_max);
			end else if (pick < 30 && tbl_count > 0) begin
				j = $urandom_range(0, tbl_count - 1);
				if (tbl_free[j])
					size = $urandom_range(1, tbl_size[j]);
				else
					size = $urandom_range(1, small_max);
			end else begin
				size = $urandom_range(1, small_max);
			end
			offer_request(MODE_ALLOC, size, addr, 1'b0, NO_GRANT);
		end else begin
			if (pick < 5) begin
				addr = '0;
			end else if (pick >= 15 && tbl_count > 0) begin
				j = $urandom_range(0, tbl_count - 1);
				addr = tbl_start[j] + ADDR_W'(hdr_reg);
				// near miss on a live payload
				if (pick < 25)
					addr = addr + 1'b1;
			end
			offer_request(MODE_RELEASE, size, addr, 1'b0, NO_GRANT);
		end
	endtask

	task automatic wait_drained();
		do @(posedge clk); while (pending_grants.size() != 0);
	endtask

	task automatic check_field(input string name, input logic [ADDR_W-1:0] want,
		input logic [ADDR_W-1:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
			fail_count++;
		end
	endtask

	// Receiver: checks each result item, then picks ready for the next cycle
	initial begin
		grant_t want;
		int     hold_left;
		int     hold_done;
		hold_left = 0;
		hold_done = 0;
		rsp_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n === 1'b1 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
				results_seen++;
				if (!$isunknown(rsp_ch.status))
					status_seen[rsp_ch.status]++;
				if (rsp_ch.reused === 1'b1)
					reused_seen++;
				if (pending_grants.size() == 0) begin
					$display("%0t: result with nothing outstanding: expected none, actual %h/%0d/%0d",
						$time, rsp_ch.result_address, rsp_ch.status, rsp_ch.reused);
					fail_count++;
				end else begin
					want = pending_grants.pop_front();
					check_field("result_address", want.addr, rsp_ch.result_address);
					check_field("status", ADDR_W'(want.status), ADDR_W'(rsp_ch.status));
					check_field("reused", ADDR_W'(want.reused), ADDR_W'(rsp_ch.reused));
				end
			end
			// long hold-off on request, otherwise random stalls
			if (hold_left > 0) begin
				hold_left--;
				rsp_ch.ready <= 1'b0;
			end else if (hold_done != hold_asks) begin
				hold_done++;
				hold_left = HOLD_CYCLES;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= ($urandom_range(0, 99) >= rsp_idle_pct);
			end
		end
	end

	// Watchdog: ends the run when no item moves on either channel for too long
	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no item moved for %0d cycles, %0d results outstanding", $time,
				quiet_cycles, pending_grants.size());
			$display("Test completed with failures");
			$finish;
		end
	end

	// Main sequence: reset, directed table, then phases of register settings
	initial begin
		int                n_items;
		int                alloc_pct;
		int                small_max;
		bit                big_ok;
		logic [ADDR_W-1:0] new_base;
		logic [ADDR_W-1:0] new_limit;
		logic [HDR_W-1:0]  new_hdr;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= CFG_HEAP_BASE;
		cfg_wdata <= '0;
		req_ch.valid <= 1'b0;
		req_ch.mode <= MODE_ALLOC;
		req_ch.request_size <= '0;
		req_ch.payload_address <= '0;
		tbl_count = 0;
		heap_brk = HEAP_BASE_RST;
		base_reg = HEAP_BASE_RST;
		limit_reg = HEAP_LIMIT_RST;
		hdr_reg = HEADER_RST;
		foreach (status_seen[s])
			status_seen[s] = 0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[r])
			offer_request(directed_rows[r].mode, directed_rows[r].size, directed_rows[r].addr,
				directed_rows[r].typed, directed_rows[r].exp);
		req_ch.valid <= 1'b0;

		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			n_items = 80;
			alloc_pct = 55;
			small_max = 256;
			big_ok = 1'b1;
			new_base = base_reg;
			new_limit = HEAP_LIMIT_RST;
			new_hdr = $urandom_range(0, 255);
			req_idle_pct = 25;
			rsp_idle_pct = 25;
			case (ph)
				0: begin
					// top base on an empty table: every append runs past the limit
					new_base = '1;
					new_hdr = HEADER_RST;
					n_items = 30;
				end
				1: begin
					// fill the table until it reports full
					new_base = 32'h0000_1000;
					new_hdr = HEADER_RST;
					n_items = 110;
					alloc_pct = 90;
					small_max = 64;
					big_ok = 1'b0;
				end
				2: begin
					new_hdr = '0;
					new_limit = (heap_brk > 32'hFFFF_DFFF) ? '1 : heap_brk + 32'h2000;
				end
				3: begin
					new_base = '1;
					new_hdr = '1;
				end
				4: begin
					new_limit = '0;
					n_items = 50;
				end
				5: begin
					new_hdr = HEADER_RST;
					n_items = 100;
					req_idle_pct = 0;
					rsp_idle_pct = 0;
				end
				6: begin
					new_base = $urandom;
				end
				default: begin
					new_base = $urandom;
					if ($urandom_range(0, 1))
						new_limit = (heap_brk > 32'hFFFE_FFFF) ? '1 :
							heap_brk + $urandom_range(0, 32'h1_0000);
				end
			endcase

			// registers change only with the block idle
			wait_drained();
			repeat (SETTLE_CYCLES) @(posedge clk);
			apply_config(new_base, new_limit, new_hdr);

			for (int k = 0; k < n_items; k++) begin
				if (ph == 5 && k == 20)
					hold_asks++;
				if (ph == 6 && k == n_items / 2) begin
					req_ch.valid <= 1'b0;
					wait_drained();
				end
				random_request(alloc_pct, small_max, big_ok);
			end
			req_ch.valid <= 1'b0;
		end

		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("Ran %0d requests (%0d directed) under %0d register settings, %0d results checked.",
			items_sent, NUM_DIRECTED, settings_run, results_seen);
		$display("Results: ok %0d (reused %0d), null %0d, heap limit %0d, full %0d, unknown %0d.",
			status_seen[ST_OK], reused_seen, status_seen[ST_NULL], status_seen[ST_LIMIT],
			status_seen[ST_FULL], status_seen[ST_UNKNOWN]);
		if (fail_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
